/* hdl/bfp_pkg.sv */
// Package for the binary log frame parser: result type, frame constants,
// phase and register codes, and the reflected CRC-32 byte update.
// Has no dependencies.
package bfp_pkg;

    localparam logic [7:0]  SYNC_A        = 8'hAA;
    localparam logic [7:0]  SYNC_B        = 8'h44;
    localparam logic [7:0]  SYNC_C        = 8'h12;
    localparam logic [15:0] HEADER_LAST   = 16'd24;
    localparam logic [1:0]  TRAILER_LAST  = 2'd3;

    localparam logic [31:0] POLY_RESET    = 32'hEDB88320;
    localparam logic [15:0] MAXLEN_RESET  = 16'd4096;

    localparam logic [7:0]  CFG_POLY      = 8'd0;
    localparam logic [7:0]  CFG_MAXLEN    = 8'd1;

    localparam logic [1:0]  PH_HUNT       = 2'd0;
    localparam logic [1:0]  PH_HEADER     = 2'd1;
    localparam logic [1:0]  PH_BODY       = 2'd2;
    localparam logic [1:0]  PH_TRAILER    = 2'd3;

    localparam logic [15:0] HB_ID_LO      = 16'd1;
    localparam logic [15:0] HB_ID_HI      = 16'd2;
    localparam logic [15:0] HB_LEN_LO     = 16'd5;
    localparam logic [15:0] HB_LEN_HI     = 16'd6;
    localparam logic [15:0] HB_TSTAT      = 16'd10;
    localparam logic [15:0] HB_WEEK_LO    = 16'd11;
    localparam logic [15:0] HB_WEEK_HI    = 16'd12;
    localparam logic [15:0] HB_MS_0       = 16'd13;
    localparam logic [15:0] HB_MS_1       = 16'd14;
    localparam logic [15:0] HB_MS_2       = 16'd15;
    localparam logic [15:0] HB_MS_3       = 16'd16;
    localparam logic [15:0] HB_RXSTAT     = 16'd17;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [15:0] byte_offset;
        logic [15:0] message_id;
        logic [15:0] body_length;
        logic [7:0]  time_status;
        logic [15:0] week_number;
        logic [31:0] week_millis;
        logic        health_bit;
        logic        crc_good;
        logic        length_error;
        logic        frame_end;
    } t_result;

    // One byte through a reflected CRC-32, LSB first, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [7:0]  b,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/bfp_parser.sv */
// Frame parser core: sync hunt, header capture, body pass-through and
// trailer check, one byte per accepted beat. Depends on bfp_pkg.
module bfp_parser import bfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_poly,
    input  logic [15:0] i_max_len,
    input  logic [31:0] i_seed,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [1:0]  r_phase,   n_phase;
    logic [15:0] r_window,  n_window;
    logic [15:0] r_cnt,     n_cnt;
    logic [15:0] r_id,      n_id;
    logic [15:0] r_len,     n_len;
    logic [7:0]  r_tstat,   n_tstat;
    logic [15:0] r_week,    n_week;
    logic [31:0] r_ms,      n_ms;
    logic        r_health,  n_health;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_trailer, n_trailer;

    logic [31:0] crc_next;
    logic [31:0] trailer_next;
    logic [16:0] cnt_inc;

    assign crc_next     = crc_byte(r_crc, i_byte, i_poly);
    assign trailer_next = r_trailer | ({24'd0, i_byte} << {r_cnt[1:0], 3'b000});
    assign cnt_inc      = {1'b0, r_cnt} + 17'd1;

    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_cnt       = r_cnt;
        n_id        = r_id;
        n_len       = r_len;
        n_tstat     = r_tstat;
        n_week      = r_week;
        n_ms        = r_ms;
        n_health    = r_health;
        n_crc       = r_crc;
        n_trailer   = r_trailer;
        o_res_valid = 1'b0;

        // Header fields always reflect the frame in progress.
        o_res              = '0;
        o_res.message_id   = r_id;
        o_res.body_length  = r_len;
        o_res.time_status  = r_tstat;
        o_res.week_number  = r_week;
        o_res.week_millis  = r_ms;
        o_res.health_bit   = r_health;

        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_window == {SYNC_A, SYNC_B} && i_byte == SYNC_C) begin
                        n_window = '0;
                        n_crc    = i_seed;
                        n_cnt    = '0;
                        n_phase  = PH_HEADER;
                    end else begin
                        n_window = {r_window[7:0], i_byte};
                    end
                end
                PH_HEADER: begin
                    n_crc = crc_next;
                    case (r_cnt)
                        HB_ID_LO:   n_id     = {8'd0, i_byte};
                        HB_ID_HI:   n_id     = {i_byte, r_id[7:0]};
                        HB_LEN_LO:  n_len    = {8'd0, i_byte};
                        HB_LEN_HI:  n_len    = {i_byte, r_len[7:0]};
                        HB_TSTAT:   n_tstat  = i_byte;
                        HB_WEEK_LO: n_week   = {8'd0, i_byte};
                        HB_WEEK_HI: n_week   = {i_byte, r_week[7:0]};
                        HB_MS_0:    n_ms     = {24'd0, i_byte};
                        HB_MS_1:    n_ms     = {16'd0, i_byte, r_ms[7:0]};
                        HB_MS_2:    n_ms     = {8'd0, i_byte, r_ms[15:0]};
                        HB_MS_3:    n_ms     = {i_byte, r_ms[23:0]};
                        HB_RXSTAT:  n_health = i_byte[0];
                        default:    n_cnt    = n_cnt;
                    endcase
                    n_cnt = cnt_inc[15:0];
                    if (r_cnt == HEADER_LAST) begin
                        n_cnt     = '0;
                        n_trailer = '0;
                        if (r_len > i_max_len) begin
                            n_phase            = PH_HUNT;
                            o_res_valid        = 1'b1;
                            o_res.kind         = 1'b1;
                            o_res.length_error = 1'b1;
                            o_res.frame_end    = 1'b1;
                        end else begin
                            n_phase = (r_len == 16'd0) ? PH_TRAILER : PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_crc             = crc_next;
                    o_res_valid       = 1'b1;
                    o_res.body_byte   = i_byte;
                    o_res.byte_offset = r_cnt;
                    n_cnt             = cnt_inc[15:0];
                    if (cnt_inc >= {1'b0, r_len}) begin
                        n_cnt     = '0;
                        n_trailer = '0;
                        n_phase   = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    n_trailer = trailer_next;
                    n_cnt     = {14'd0, r_cnt[1:0] + 2'd1};
                    if (r_cnt[1:0] == TRAILER_LAST) begin
                        n_cnt           = '0;
                        n_phase         = PH_HUNT;
                        o_res_valid     = 1'b1;
                        o_res.kind      = 1'b1;
                        o_res.crc_good  = (trailer_next == r_crc);
                        o_res.frame_end = 1'b1;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_window <= '0;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_len     <= n_len;
        r_tstat   <= n_tstat;
        r_week    <= n_week;
        r_ms      <= n_ms;
        r_health  <= n_health;
        r_crc     <= n_crc;
        r_trailer <= n_trailer;
    end

endmodule

/* hdl/binary_log_frame_parser_crc32.sv */
// Top level of the binary log frame parser with CRC-32 trailer check.
// Depends on bfp_pkg and bfp_parser.
//
// Usage:
// Input channel: one raw receiver byte per beat on i_data_byte, taken when
// i_data_valid is high and o_data_stall is low. Result channel: o_res_valid
// with one result per beat, taken when i_res_stall is low. A body byte gives
// a kind 0 result carrying the byte and its offset; the end of each frame
// (good trailer, bad trailer, or body too long) gives one kind 1 status.
// An accepted byte's result is registered in the output register, or in the skid
// buffer while the output waits. Throughput is one byte per cycle while
// o_data_stall is low; the per-byte CRC update is one 8-step reflected shift
// network feeding the parser's CRC register. A one-entry skid buffer behind
// the output register lets the block take a byte while a result waits, and
// o_data_stall rises when it is full. Configuration: i_cfg_index 0 writes the
// CRC polynomial, 1 the body length limit; other indexes are ignored.
// o_cfg_ready is always high. After reset, and after every polynomial write,
// the block computes the CRC of the three sync bytes with o_data_stall high.
// Reset returns the parser to the sync hunt with both registers at defaults.
module binary_log_frame_parser_crc32 import bfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_data_valid,
    output logic        o_data_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic        o_kind,
    output logic [7:0]  o_body_byte,
    output logic [15:0] o_byte_offset,
    output logic [15:0] o_message_id,
    output logic [15:0] o_body_length,
    output logic [7:0]  o_time_status,
    output logic [15:0] o_week_number,
    output logic [31:0] o_week_millis,
    output logic        o_health_bit,
    output logic        o_crc_good,
    output logic        o_length_error,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_poly;
    logic [15:0] r_max_len;

    logic        r_seed_busy;
    logic [1:0]  r_seed_step;
    logic [31:0] r_seed;
    logic [7:0]  seed_byte;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        accept;
    logic        cfg_write;
    logic        res_valid;
    t_result     res;
    logic        out_free;

    assign o_cfg_ready  = 1'b1;
    assign cfg_write    = i_cfg_valid & o_cfg_ready;
    assign o_data_stall = r_skid_valid | r_seed_busy;
    assign accept       = i_data_valid & ~o_data_stall;
    assign out_free     = ~r_out_valid | ~i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly    <= POLY_RESET;
            r_max_len <= MAXLEN_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_POLY:   r_poly    <= i_cfg_data;
                CFG_MAXLEN: r_max_len <= i_cfg_data[15:0];
                default:    r_max_len <= r_max_len;
            endcase
        end
    end

    // The CRC of the three sync bytes seeds every frame; it is rebuilt one
    // byte per cycle whenever the polynomial changes.
    always_comb begin
        case (r_seed_step)
            2'd0:    seed_byte = SYNC_A;
            2'd1:    seed_byte = SYNC_B;
            default: seed_byte = SYNC_C;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (cfg_write && i_cfg_index == CFG_POLY)) begin
            r_seed_busy <= 1'b1;
            r_seed_step <= 2'd0;
            r_seed      <= '0;
        end else if (r_seed_busy) begin
            r_seed      <= crc_byte(r_seed, seed_byte, r_poly);
            r_seed_step <= r_seed_step + 2'd1;
            if (r_seed_step == 2'd2) begin
                r_seed_busy <= 1'b0;
            end
        end
    end

    bfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_data_byte),
        .i_poly      (r_poly),
        .i_max_len   (r_max_len),
        .i_seed      (r_seed),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= res_valid;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_body_byte    = r_out.body_byte;
    assign o_byte_offset  = r_out.byte_offset;
    assign o_message_id   = r_out.message_id;
    assign o_body_length  = r_out.body_length;
    assign o_time_status  = r_out.time_status;
    assign o_week_number  = r_out.week_number;
    assign o_week_millis  = r_out.week_millis;
    assign o_health_bit   = r_out.health_bit;
    assign o_crc_good     = r_out.crc_good;
    assign o_length_error = r_out.length_error;
    assign o_frame_end    = r_out.frame_end;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench for binary_log_frame_parser_crc32: frames, noise and register settings go in,
// every result is checked against an in-bench parser model. Depends on bfp_pkg and the RTL.
module tb import bfp_pkg::*; ();

    localparam int          RANDOM_BYTES  = 500;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          LONG_HOLD     = 80;
    localparam int          RUN_LIMIT_NS  = 2_000_000;
    localparam logic [7:0]  CFG_UNUSED_LO = 8'd2;
    localparam logic [7:0]  CFG_UNUSED_HI = 8'hFF;
    localparam logic [15:0] ID_TIMED      = 16'd43;
    localparam logic [31:0] POLY_CASTAG   = 32'h82F63B78;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_data_valid;
    logic        o_data_stall;
    logic [7:0]  i_data_byte;
    logic        o_res_valid;
    logic        i_res_stall;
    logic        o_kind;
    logic [7:0]  o_body_byte;
    logic [15:0] o_byte_offset;
    logic [15:0] o_message_id;
    logic [15:0] o_body_length;
    logic [7:0]  o_time_status;
    logic [15:0] o_week_number;
    logic [31:0] o_week_millis;
    logic        o_health_bit;
    logic        o_crc_good;
    logic        o_length_error;
    logic        o_frame_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    binary_log_frame_parser_crc32 dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Parser model state and its copy of the registers.
    logic [31:0] crc_poly    = POLY_RESET;
    logic [15:0] max_len     = MAXLEN_RESET;
    logic [15:0] hunt_win    = '0;
    logic [1:0]  parse_ph    = PH_HUNT;
    logic [15:0] step_cnt    = '0;
    logic [15:0] hdr_id      = '0;
    logic [15:0] hdr_len     = '0;
    logic [7:0]  hdr_tstat   = '0;
    logic [15:0] hdr_week    = '0;
    logic [31:0] hdr_ms      = '0;
    logic        hdr_health  = 1'b0;
    logic [31:0] run_crc     = '0;
    logic [31:0] trailer_acc = '0;

    t_result parsed_q[$];
    int      errors       = 0;
    int      bytes_taken  = 0;
    bit      quiet        = 1'b0;
    bit      hold_request = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Reflected CRC update, feeding one data bit per shift.
    function automatic logic [31:0] crc_next(input logic [31:0] acc, input logic [7:0] d,
                                             input logic [31:0] poly);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ d[i]) ? poly : 32'd0);
        end
        return r;
    endfunction

    function automatic t_result make_result(input logic kind, input logic [7:0] d,
                                            input logic [15:0] off, input logic good,
                                            input logic lerr);
        t_result r;
        r.kind         = kind;
        r.body_byte    = d;
        r.byte_offset  = off;
        r.message_id   = hdr_id;
        r.body_length  = hdr_len;
        r.time_status  = hdr_tstat;
        r.week_number  = hdr_week;
        r.week_millis  = hdr_ms;
        r.health_bit   = hdr_health;
        r.crc_good     = good;
        r.length_error = lerr;
        r.frame_end    = kind;
        return r;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [15:0] n;
        n = step_cnt;
        case (parse_ph)
            PH_HUNT: begin
                if (hunt_win == {SYNC_A, SYNC_B} && b == SYNC_C) begin
                    hunt_win = '0;
                    run_crc  = crc_next(crc_next(crc_next(32'd0, SYNC_A, crc_poly),
                                                 SYNC_B, crc_poly), SYNC_C, crc_poly);
                    step_cnt = '0;
                    parse_ph = PH_HEADER;
                end else begin
                    hunt_win = {hunt_win[7:0], b};
                end
            end
            PH_HEADER: begin
                run_crc = crc_next(run_crc, b, crc_poly);
                case (n)
                    HB_ID_LO:   hdr_id = {8'd0, b};
                    HB_ID_HI:   hdr_id[15:8] = b;
                    HB_LEN_LO:  hdr_len = {8'd0, b};
                    HB_LEN_HI:  hdr_len[15:8] = b;
                    HB_TSTAT:   hdr_tstat = b;
                    HB_WEEK_LO: hdr_week = {8'd0, b};
                    HB_WEEK_HI: hdr_week[15:8] = b;
                    HB_MS_0:    hdr_ms = {24'd0, b};
                    HB_MS_1:    hdr_ms[15:8] = b;
                    HB_MS_2:    hdr_ms[23:16] = b;
                    HB_MS_3:    hdr_ms[31:24] = b;
                    HB_RXSTAT:  hdr_health = b[0];
                    default: ;
                endcase
                step_cnt = n + 16'd1;
                if (n == HEADER_LAST) begin
                    step_cnt    = '0;
                    trailer_acc = '0;
                    if (hdr_len > max_len) begin
                        parse_ph = PH_HUNT;
                        parsed_q.push_back(make_result(1'b1, 8'd0, 16'd0, 1'b0, 1'b1));
                    end else begin
                        parse_ph = (hdr_len == 16'd0) ? PH_TRAILER : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                run_crc = crc_next(run_crc, b, crc_poly);
                parsed_q.push_back(make_result(1'b0, b, n, 1'b0, 1'b0));
                step_cnt = n + 16'd1;
                if (int'(n) + 1 >= int'(hdr_len)) begin
                    step_cnt    = '0;
                    trailer_acc = '0;
                    parse_ph    = PH_TRAILER;
                end
            end
            default: begin
                trailer_acc = trailer_acc | (32'(b) << (8 * n[1:0]));
                step_cnt    = {14'd0, n[1:0]} + 16'd1;
                if (n[1:0] == TRAILER_LAST) begin
                    step_cnt = '0;
                    parse_ph = PH_HUNT;
                    parsed_q.push_back(make_result(1'b1, 8'd0, 16'd0,
                                                   trailer_acc == run_crc, 1'b0));
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1 && i_res_stall === 1'b0) begin
            if (parsed_q.size() == 0) begin
                report_mismatch("unexpected result beat", {31'd0, o_kind}, 32'd0);
            end else begin
                want = parsed_q.pop_front();
                check_field("kind", 32'(o_kind), 32'(want.kind));
                check_field("body_byte", 32'(o_body_byte), 32'(want.body_byte));
                check_field("byte_offset", 32'(o_byte_offset), 32'(want.byte_offset));
                check_field("message_id", 32'(o_message_id), 32'(want.message_id));
                check_field("body_length", 32'(o_body_length), 32'(want.body_length));
                check_field("time_status", 32'(o_time_status), 32'(want.time_status));
                check_field("week_number", 32'(o_week_number), 32'(want.week_number));
                check_field("week_millis", o_week_millis, want.week_millis);
                check_field("health_bit", 32'(o_health_bit), 32'(want.health_bit));
                check_field("crc_good", 32'(o_crc_good), 32'(want.crc_good));
                check_field("length_error", 32'(o_length_error), 32'(want.length_error));
                check_field("frame_end", 32'(o_frame_end), 32'(want.frame_end));
            end
        end
    end

    // Result-side back-pressure; a long hold is counted out here on request.
    initial begin : stall_driver
        int span;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_res_stall <= 1'b1;
                span = LONG_HOLD;
            end else if (quiet || $urandom_range(0, 99) < 60) begin
                i_res_stall <= 1'b0;
                span = quiet ? 1 : pick_gap() + 1;
            end else begin
                i_res_stall <= 1'b1;
                span = pick_gap() + 1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_data_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        do @(posedge i_clk); while (o_data_stall);
        parse_byte(b);
        bytes_taken++;
    endtask

    // Stop offering bytes and wait until every expected beat is out.
    task automatic settle();
        i_data_valid <= 1'b0;
        @(posedge i_clk);
        while (parsed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_POLY) crc_poly = val;
        else if (idx == CFG_MAXLEN) max_len = val[15:0];
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] poly, input logic [15:0] limit);
        settle();
        write_reg(CFG_POLY, poly, 1'b1);
        write_reg(CFG_MAXLEN, {16'd0, limit}, 1'b0);
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input logic [7:0] tstat, input logic [15:0] week,
                              input logic [31:0] ms, input logic [7:0] rxstat,
                              input bit bad_crc, input bit sync_in_body);
        logic [7:0]  hdr [25];
        logic [7:0]  d;
        logic [31:0] c;
        int          mark;
        bit          too_long;
        too_long = (len > max_len);
        foreach (hdr[i]) hdr[i] = 8'($urandom);
        hdr[HB_ID_LO]   = id[7:0];
        hdr[HB_ID_HI]   = id[15:8];
        hdr[HB_LEN_LO]  = len[7:0];
        hdr[HB_LEN_HI]  = len[15:8];
        hdr[HB_TSTAT]   = tstat;
        hdr[HB_WEEK_LO] = week[7:0];
        hdr[HB_WEEK_HI] = week[15:8];
        hdr[HB_MS_0]    = ms[7:0];
        hdr[HB_MS_1]    = ms[15:8];
        hdr[HB_MS_2]    = ms[23:16];
        hdr[HB_MS_3]    = ms[31:24];
        hdr[HB_RXSTAT]  = rxstat;
        c = crc_next(crc_next(crc_next(32'd0, SYNC_A, crc_poly), SYNC_B, crc_poly),
                     SYNC_C, crc_poly);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        for (int i = 0; i < 25; i++) begin
            c = crc_next(c, hdr[i], crc_poly);
            send_byte(hdr[i]);
        end
        if (too_long) return;
        mark = (sync_in_body && len >= 16'd3) ? $urandom_range(0, int'(len) - 3) : -10;
        for (int i = 0; i < int'(len); i++) begin
            if (i == mark) d = SYNC_A;
            else if (i == mark + 1) d = SYNC_B;
            else if (i == mark + 2) d = SYNC_C;
            else d = 8'($urandom);
            c = crc_next(c, d, crc_poly);
            send_byte(d);
        end
        if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++) send_byte(c[8*i +: 8]);
    endtask

    task automatic send_random_frame();
        logic [15:0] len;
        logic [15:0] id;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 60) len = 16'($urandom_range(0, 24));
        else if (r < 88) len = 16'($urandom_range(25, 80));
        else if (r < 95) len = 16'($urandom_range(81, 300));
        else if (max_len != 16'hFFFF) len = 16'($urandom_range(int'(max_len) + 1, 65535));
        else len = 16'($urandom_range(0, 8));
        id = ($urandom_range(0, 2) == 0) ? ID_TIMED : 16'($urandom);
        send_frame(id, len, 8'($urandom), 16'($urandom), $urandom, 8'($urandom),
                   $urandom_range(0, 99) < 25, $urandom_range(0, 99) < 15);
    endtask

    // Random bytes while hunting, biased toward sync values but never completing a sync.
    task automatic send_noise();
        int         cnt;
        int         r;
        logic [7:0] d;
        cnt = $urandom_range(1, 10);
        repeat (cnt) begin
            r = $urandom_range(0, 5);
            d = (r == 0) ? SYNC_A : (r == 1) ? SYNC_B : (r == 2) ? SYNC_C : 8'($urandom);
            if (hunt_win == {SYNC_A, SYNC_B} && d == SYNC_C) d = ~d;
            send_byte(d);
        end
        if ($urandom_range(0, 2) == 0) send_byte(SYNC_A);
    endtask

    task automatic send_broken_frame();
        int k;
        k = $urandom_range(0, 24);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        repeat (k) send_byte(8'($urandom));
        // The cut frame swallows what follows; feed filler until the parser hunts again.
        while (parse_ph != PH_HUNT) send_byte(8'($urandom));
    endtask

    task automatic random_config();
        int          r;
        logic [31:0] poly;
        logic [15:0] limit;
        r = $urandom_range(0, 99);
        if (r < 40) poly = POLY_RESET;
        else if (r < 60) poly = $urandom;
        else if (r < 70) poly = POLY_CASTAG;
        else if (r < 85) poly = 32'd0;
        else poly = 32'hFFFFFFFF;
        r = $urandom_range(0, 99);
        if (r < 30) limit = MAXLEN_RESET;
        else if (r < 50) limit = 16'hFFFF;
        else if (r < 75) limit = 16'($urandom_range(100, 1000));
        else if (r < 92) limit = 16'($urandom_range(1, 40));
        else limit = 16'd0;
        configure(poly, limit);
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(ID_TIMED, 16'd8, 8'd180, 16'd2200, 32'd345600000, 8'h00, 1'b0, 1'b0);
        send_frame(16'd7, 16'd5, 8'd20, 16'd1, 32'd1000, 8'h01, 1'b1, 1'b0);
        send_frame(16'd8, 16'd0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0, 1'b0);
        send_frame(16'd9, MAXLEN_RESET + 16'd1, 8'd1, 16'd2, 32'd3, 8'h01, 1'b0, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_frame(16'hFFFF, 16'd1, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 1'b0, 1'b0);
        send_frame(16'h0000, 16'd2, 8'h00, 16'h0000, 32'h00000000, 8'hFE, 1'b0, 1'b0);
        send_frame(16'h5A5A, 16'hFFFF, 8'hA5, 16'h8001, 32'h80000001, 8'h01, 1'b0, 1'b0);
    endtask

    task automatic test_length_limit();
        configure(POLY_RESET, 16'd20);
        send_frame(16'd1, 16'd20, 8'd3, 16'd4, 32'd5, 8'd1, 1'b0, 1'b0);
        send_frame(16'd2, 16'd21, 8'd3, 16'd4, 32'd5, 8'd1, 1'b0, 1'b0);
        configure(POLY_RESET, 16'd0);
        send_frame(16'd3, 16'd0, 8'd3, 16'd4, 32'd5, 8'd0, 1'b0, 1'b0);
        send_frame(16'd4, 16'd1, 8'd3, 16'd4, 32'd5, 8'd0, 1'b0, 1'b0);
        configure(POLY_RESET, 16'hFFFF);
        send_frame(16'd5, 16'd3, 8'd3, 16'd4, 32'd5, 8'd1, 1'b1, 1'b0);
    endtask

    task automatic test_sync_hunt();
        logic [7:0] d;
        configure(POLY_RESET, MAXLEN_RESET);
        // Partial sync just ahead of a real one.
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_frame(16'd11, 16'd4, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b0);
        send_byte(SYNC_A);
        send_frame(16'd12, 16'd10, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b1);
        // Sync bytes at the tail of an oversized header must not start a new frame.
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        for (int i = 0; i < 25; i++) begin
            if (i == HB_LEN_LO || i == HB_LEN_HI) d = 8'hFF;
            else if (i == HEADER_LAST - 1) d = SYNC_A;
            else if (i == HEADER_LAST) d = SYNC_B;
            else d = 8'($urandom);
            send_byte(d);
        end
        send_byte(SYNC_C);
        send_byte(SYNC_B);
        send_byte(SYNC_C);
        send_frame(16'd13, 16'd3, 8'd0, 16'd0, 32'd0, 8'd0, 1'b0, 1'b1);
    endtask

    task automatic test_config_regs();
        configure(32'd0, 16'd64);
        send_frame(16'd21, 16'd6, 8'd1, 16'd1, 32'd1, 8'd1, 1'b0, 1'b0);
        configure(32'hFFFFFFFF, 16'd64);
        send_frame(16'd22, 16'd6, 8'd1, 16'd1, 32'd1, 8'd1, 1'b0, 1'b0);
        send_frame(16'd23, 16'd6, 8'd1, 16'd1, 32'd1, 8'd1, 1'b1, 1'b0);
        configure($urandom, 16'd64);
        send_frame(16'd24, 16'd9, 8'd1, 16'd1, 32'd1, 8'd1, 1'b0, 1'b0);
        // Writes to unused indexes must leave both registers alone.
        settle();
        write_reg(CFG_UNUSED_LO, $urandom, 1'b1);
        write_reg(CFG_UNUSED_HI, $urandom, 1'b0);
        send_frame(16'd25, 16'd64, 8'd1, 16'd1, 32'd1, 8'd1, 1'b0, 1'b0);
        send_frame(16'd26, 16'd65, 8'd1, 16'd1, 32'd1, 8'd1, 1'b0, 1'b0);
        configure(POLY_RESET, MAXLEN_RESET);
    endtask

    task automatic test_backpressure();
        settle();
        quiet = 1'b1;
        hold_request = 1'b1;
        send_frame(16'd31, 16'd40, 8'd2, 16'd3, 32'd4, 8'd1, 1'b0, 1'b0);
        send_frame(16'd32, 16'd12, 8'd2, 16'd3, 32'd4, 8'd0, 1'b0, 1'b0);
        quiet = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        int start;
        int frames;
        int r;
        start  = bytes_taken;
        frames = 0;
        while (bytes_taken - start < RANDOM_BYTES) begin
            if (frames % 10 == 9) begin
                quiet = 1'b0;
                random_config();
            end
            quiet = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 3) hold_request = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 80) send_random_frame();
            else if (r < 90) send_noise();
            else if (max_len <= 16'd1000) send_broken_frame();
            else send_random_frame();
            frames++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_data_valid = 1'b0;
        i_data_byte  = 8'd0;
        i_res_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_POLY;
        i_cfg_data   = 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_length_limit();
        test_sync_hunt();
        test_config_regs();
        test_backpressure();
        test_random_traffic();
        settle();

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* binary_log_frame_parser_crc32.f */
hdl/bfp_pkg.sv
hdl/bfp_parser.sv
hdl/binary_log_frame_parser_crc32.sv
sim/tb.sv
